[rtl/cms_pkg.sv]
// Package: types, constants and hash seeds for the count-min frequency sketch.
package cms_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int NUM_HASHES  = 6;
	localparam int CTR_W       = 8;

	localparam logic [31:0] RS_STEP       = 32'd378551;
	localparam logic [31:0] RS_START_MULT = 32'd63689;
	localparam logic [31:0] JS_SEED       = 32'd1315423911;
	localparam logic [31:0] BKDR_SEED     = 32'd131;
	localparam logic [31:0] DJB_SEED      = 32'd5381;

	localparam logic [1:0] CMD_INC   = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_DEC   = 2'd2;

	localparam logic REG_COUNT_LIMIT     = 1'b0;
	localparam logic REG_ADMIT_THRESHOLD = 1'b1;

	localparam logic [CTR_W-1:0] COUNT_LIMIT_RST = 8'd255;
	localparam logic [CTR_W-1:0] ADMIT_THR_RST   = 8'd1;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] key_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] estimate;
		logic       admit;
	} out_item_t;

	typedef struct packed {
		logic clr;
		logic fold;
		logic rd;
		logic cmp;
		logic wr;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_done;
	} dp_status_t;

endpackage

[rtl/cms_ram.sv]
// Generic single-port-write, registered-read RAM.
module cms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/cms_ctrl.sv]
// Controller: clearing pass, byte intake, table read, minimum and update sequencing.
module cms_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                last_byte,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  cms_pkg::dp_status_t status,
	output cms_pkg::dp_cmd_t    cmd
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_MIN   = 3'd3;
	localparam logic [2:0] S_WRITE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (status.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.fold = in_valid;
				if (in_valid && last_byte) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_MIN;
			end
			S_MIN: begin
				cmd.cmp = 1'b1;
				state_d = S_WRITE;
			end
			S_WRITE: begin
				if (out_free) begin
					cmd.wr  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.wr) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/cms_dp.sv]
// Datapath: six string hashes, counter tables, minimum, update and result register.
module cms_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  cms_pkg::in_item_t   in_item,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data,
	input  cms_pkg::dp_cmd_t    cmd,
	output cms_pkg::dp_status_t status,
	output cms_pkg::out_item_t  out_item
);

	localparam int IW = cms_pkg::IDX_W;
	localparam int NH = cms_pkg::NUM_HASHES;
	localparam int CW = cms_pkg::CTR_W;

	logic [31:0]   h_q [NH];
	logic [31:0]   h_d [NH];
	logic [31:0]   mult_q;
	logic          odd_q;
	logic [1:0]    cmd_q;
	logic [IW-1:0] clr_cnt_q;
	logic [CW-1:0] limit_q;
	logic [CW-1:0] thr_q;
	logic [CW-1:0] est_q;
	logic [CW-1:0] est_d;
	logic [CW-1:0] rdata [NH];
	logic [CW-1:0] wdata [NH];
	logic [31:0]   c;
	logic [31:0]   t5;
	cms_pkg::out_item_t out_q;

	assign c = {{24{in_item.key_byte[7]}}, in_item.key_byte};
	assign status.clr_done = (clr_cnt_q == {IW{1'b1}});
	assign out_item = out_q;

	always_comb begin
		h_d[0] = h_q[0] * mult_q + c;
		h_d[1] = h_q[1] ^ ((h_q[1] << 5) + c + (h_q[1] >> 2));
		h_d[2] = h_q[2] * cms_pkg::BKDR_SEED + c;
		h_d[3] = c + (h_q[3] << 6) + (h_q[3] << 16) - h_q[3];
		h_d[4] = h_q[4] + (h_q[4] << 5) + c;
		if (!odd_q) begin
			t5 = (h_q[5] << 7) ^ c ^ (h_q[5] >> 3);
		end else begin
			t5 = ~((h_q[5] << 11) ^ c ^ (h_q[5] >> 5));
		end
		h_d[5] = h_q[5] ^ t5;
	end

	always_comb begin
		est_d = rdata[0];
		for (int i = 1; i < NH; i++) begin
			if (rdata[i] < est_d) begin
				est_d = rdata[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NH; i++) begin
			wdata[i] = rdata[i];
			if (cmd.clr) begin
				wdata[i] = '0;
			end else if (cmd_q == cms_pkg::CMD_INC) begin
				if (rdata[i] < limit_q) begin
					wdata[i] = rdata[i] + CW'(1);
				end
			end else if (cmd_q == cms_pkg::CMD_DEC) begin
				wdata[i] = (rdata[i] > est_q) ? rdata[i] - est_q : '0;
			end
		end
	end

	for (genvar g = 0; g < NH; g++) begin : g_tbl
		cms_ram #(
			.WIDTH(CW),
			.DEPTH(cms_pkg::TABLE_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (cmd.clr || cmd.wr),
			.waddr(cmd.clr ? clr_cnt_q : h_q[g][IW-1:0]),
			.wdata(wdata[g]),
			.re   (cmd.rd),
			.raddr(h_q[g][IW-1:0]),
			.rdata(rdata[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0]    <= '0;
			h_q[1]    <= cms_pkg::JS_SEED;
			h_q[2]    <= '0;
			h_q[3]    <= '0;
			h_q[4]    <= cms_pkg::DJB_SEED;
			h_q[5]    <= '0;
			mult_q    <= cms_pkg::RS_START_MULT;
			odd_q     <= 1'b0;
			clr_cnt_q <= '0;
			limit_q   <= cms_pkg::COUNT_LIMIT_RST;
			thr_q     <= cms_pkg::ADMIT_THR_RST;
		end else begin
			if (cmd.clr) begin
				clr_cnt_q <= clr_cnt_q + IW'(1);
			end
			if (cmd.fold) begin
				for (int i = 0; i < NH; i++) begin
					h_q[i] <= h_d[i];
				end
				mult_q <= mult_q * cms_pkg::RS_STEP;
				odd_q  <= !odd_q;
			end else if (cmd.wr) begin
				h_q[0] <= '0;
				h_q[1] <= cms_pkg::JS_SEED;
				h_q[2] <= '0;
				h_q[3] <= '0;
				h_q[4] <= cms_pkg::DJB_SEED;
				h_q[5] <= '0;
				mult_q <= cms_pkg::RS_START_MULT;
				odd_q  <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					cms_pkg::REG_COUNT_LIMIT:     limit_q <= cfg_data;
					cms_pkg::REG_ADMIT_THRESHOLD: thr_q   <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fold && in_item.last_byte) begin
			cmd_q <= in_item.cmd;
		end
		if (cmd.cmp) begin
			est_q <= est_d;
		end
		if (cmd.wr) begin
			out_q.estimate <= est_q;
			out_q.admit    <= (est_q > thr_q);
		end
	end

endmodule

[rtl/count_min_frequency_sketch_top.sv]
// Top level of the count-min frequency sketch.
//  channel  | handshake             | payload
//  input    | in_valid / in_stall   | in_item   (cmd, key_byte, last_byte)
//  output   | out_valid / out_stall | out_item  (estimate, admit)
//  config   | cfg_we                | cfg_index, cfg_data
// A non-last byte is folded into the hashes; a last byte is folded, then
// the RAMs are read (registered), the minimum taken and counters written.
// The write cycle waits while an earlier result is still held and stalled.
// After reset a clearing pass zeroes all 4096 table rows, one row per
// cycle; in_stall is high during it.
module count_min_frequency_sketch_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  cms_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output cms_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data
);

	cms_pkg::dp_cmd_t    cmd;
	cms_pkg::dp_status_t status;

	cms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last_byte(in_item.last_byte),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	cms_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status),
		.out_item (out_item)
	);

endmodule

[bench/tb_count_min_frequency_sketch_top.sv]
// Testbench for the count-min frequency sketch: directed and random key streams checked against a predictor.
module tb_count_min_frequency_sketch_top;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	cms_pkg::in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	cms_pkg::out_item_t out_item;
	logic      cfg_we;
	logic      cfg_index;
	logic [7:0] cfg_data;

	count_min_frequency_sketch_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	localparam int WATCHDOG_LIMIT = 30000;

	cms_pkg::in_item_t  pending_items[$];
	cms_pkg::out_item_t expected_estimates[$];
	int        fail_count = 0;
	bit        calm = 0;
	int        in_gap = 0;
	int        out_gap = 0;
	int        quiet_cycles = 0;

	// predictor state
	bit [31:0] hsh [cms_pkg::NUM_HASHES];
	bit [31:0] rs_mult;
	bit        ap_odd;
	bit [7:0]  counters [cms_pkg::NUM_HASHES][cms_pkg::TABLE_DEPTH];
	bit [7:0]  lim_model;
	bit [7:0]  thr_model;

	logic [7:0] key_pool [8][6];
	int         key_len [8];

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	task automatic reload_hashes();
		hsh[0] = 32'd0; hsh[1] = cms_pkg::JS_SEED; hsh[2] = 32'd0;
		hsh[3] = 32'd0; hsh[4] = cms_pkg::DJB_SEED; hsh[5] = 32'd0;
		rs_mult = cms_pkg::RS_START_MULT;
		ap_odd = 1'b0;
	endtask

	task automatic fold_key_byte(input logic [7:0] b);
		bit [31:0] c;
		c = {{24{b[7]}}, b};
		hsh[0] = hsh[0] * rs_mult + c;
		rs_mult = rs_mult * cms_pkg::RS_STEP;
		hsh[1] = hsh[1] ^ ((hsh[1] << 5) + c + (hsh[1] >> 2));
		hsh[2] = hsh[2] * cms_pkg::BKDR_SEED + c;
		hsh[3] = c + (hsh[3] << 6) + (hsh[3] << 16) - hsh[3];
		hsh[4] = hsh[4] + (hsh[4] << 5) + c;
		if (!ap_odd)
			hsh[5] = hsh[5] ^ ((hsh[5] << 7) ^ c ^ (hsh[5] >> 3));
		else
			hsh[5] = hsh[5] ^ ~((hsh[5] << 11) ^ c ^ (hsh[5] >> 5));
		ap_odd = ~ap_odd;
	endtask

	task automatic predict_item(input cms_pkg::in_item_t it);
		bit [cms_pkg::IDX_W-1:0] idx [cms_pkg::NUM_HASHES];
		bit [7:0] est;
		cms_pkg::out_item_t r;
		fold_key_byte(it.key_byte);
		if (it.last_byte) begin
			est = 8'd255;
			for (int i = 0; i < cms_pkg::NUM_HASHES; i++) begin
				idx[i] = hsh[i][cms_pkg::IDX_W-1:0];
				if (counters[i][idx[i]] < est) est = counters[i][idx[i]];
			end
			r.estimate = est;
			r.admit = est > thr_model;
			expected_estimates.push_back(r);
			for (int i = 0; i < cms_pkg::NUM_HASHES; i++) begin
				if (it.cmd == cms_pkg::CMD_INC) begin
					if (counters[i][idx[i]] < lim_model)
						counters[i][idx[i]] = counters[i][idx[i]] + 8'd1;
				end else if (it.cmd == cms_pkg::CMD_DEC) begin
					counters[i][idx[i]] = (counters[i][idx[i]] > est) ?
						counters[i][idx[i]] - est : 8'd0;
				end
			end
			reload_hashes();
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
			in_gap = 0;
		end else begin
			if (in_valid && !in_stall) predict_item(in_item);
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					in_item <= pending_items.pop_front();
					in_valid <= 1'b1;
					if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 5);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_estimates.size() == 0) begin
					$error("unexpected item: estimate %0d admit %0d",
						out_item.estimate, out_item.admit);
					fail_count++;
				end else begin
					cms_pkg::out_item_t e;
					e = expected_estimates.pop_front();
					if (out_item.estimate !== e.estimate) begin
						$error("estimate: expected %0d actual %0d",
							e.estimate, out_item.estimate);
						fail_count++;
					end
					if (out_item.admit !== e.admit) begin
						$error("admit: expected %0d actual %0d", e.admit, out_item.admit);
						fail_count++;
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_gap = $urandom_range(0, 4);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_count_min_frequency_sketch_top: FAIL");
			$finish;
		end
	end

	task automatic push_byte(input logic [1:0] cmd, input logic [7:0] b, input logic last);
		cms_pkg::in_item_t it;
		it.cmd = cmd; it.key_byte = b; it.last_byte = last;
		pending_items.push_back(it);
	endtask

	task automatic push_pool_key(input int k, input logic [1:0] cmd);
		for (int j = 0; j < key_len[k]; j++)
			push_byte(logic'($urandom_range(0, 3)) ? cmd : cmd, key_pool[k][j], j == key_len[k] - 1);
	endtask

	task automatic wait_idle();
		wait (pending_items.size() == 0 && !in_valid && expected_estimates.size() == 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == cms_pkg::REG_COUNT_LIMIT) lim_model = v;
		else thr_model = v;
	endtask

	task automatic random_phase(input int n_bytes);
		int r, len;
		logic [1:0] cmd;
		while (pending_items.size() < n_bytes) begin
			r = $urandom_range(0, 99);
			cmd = (r % 3 == 0) ? 2'($urandom_range(0, 3)) : cms_pkg::CMD_INC;
			if (r < 80) begin
				push_pool_key($urandom_range(0, 7), cmd);
			end else if (r < 93) begin
				len = $urandom_range(1, 8);
				for (int j = 0; j < len; j++)
					push_byte(2'($urandom_range(0, 3)), 8'($urandom), j == len - 1);
			end else begin
				push_byte(2'($urandom_range(0, 3)), 8'($urandom), 1'b0);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = cms_pkg::REG_COUNT_LIMIT;
		cfg_data = 8'd0;
		reload_hashes();
		for (int i = 0; i < cms_pkg::NUM_HASHES; i++)
			for (int j = 0; j < cms_pkg::TABLE_DEPTH; j++) counters[i][j] = 8'd0;
		lim_model = cms_pkg::COUNT_LIMIT_RST;
		thr_model = cms_pkg::ADMIT_THR_RST;
		for (int k = 0; k < 8; k++) begin
			key_len[k] = $urandom_range(1, 6);
			for (int j = 0; j < 6; j++) key_pool[k][j] = 8'($urandom);
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: byte extremes, every cmd, repeats to build counts, decrease
		push_byte(cms_pkg::CMD_QUERY, 8'h00, 1'b1);
		push_byte(cms_pkg::CMD_INC, 8'h00, 1'b1);
		push_byte(cms_pkg::CMD_INC, 8'h00, 1'b1);
		push_byte(cms_pkg::CMD_INC, 8'h00, 1'b1);
		push_byte(cms_pkg::CMD_QUERY, 8'h00, 1'b1);
		push_byte(cms_pkg::CMD_DEC, 8'h00, 1'b1);
		push_byte(cms_pkg::CMD_QUERY, 8'h00, 1'b1);
		push_byte(cms_pkg::CMD_INC, 8'hFF, 1'b0);
		push_byte(cms_pkg::CMD_INC, 8'h80, 1'b0);
		push_byte(cms_pkg::CMD_INC, 8'h7F, 1'b1);
		push_byte(cms_pkg::CMD_INC, 8'hFF, 1'b0);
		push_byte(cms_pkg::CMD_INC, 8'h80, 1'b0);
		push_byte(cms_pkg::CMD_INC, 8'h7F, 1'b1);
		push_byte(2'd3, 8'hFF, 1'b0);
		push_byte(2'd3, 8'h80, 1'b0);
		push_byte(2'd3, 8'h7F, 1'b1);
		push_byte(cms_pkg::CMD_DEC, 8'h00, 1'b0);
		push_byte(cms_pkg::CMD_DEC, 8'h00, 1'b1);
		wait_idle();

		write_reg(cms_pkg::REG_COUNT_LIMIT, 8'd2);
		write_reg(cms_pkg::REG_ADMIT_THRESHOLD, 8'd0);
		for (int j = 0; j < 4; j++) push_byte(cms_pkg::CMD_INC, 8'h55, 1'b1);
		push_byte(cms_pkg::CMD_QUERY, 8'h55, 1'b1);
		wait_idle();

		random_phase(240);
		wait_idle();

		write_reg(cms_pkg::REG_COUNT_LIMIT, 8'd0);
		write_reg(cms_pkg::REG_ADMIT_THRESHOLD, 8'd255);
		random_phase(150);
		wait_idle();

		write_reg(cms_pkg::REG_COUNT_LIMIT, 8'd255);
		write_reg(cms_pkg::REG_ADMIT_THRESHOLD, 8'd3);
		random_phase(300);
		wait_idle();

		write_reg(cms_pkg::REG_COUNT_LIMIT, 8'd1);
		write_reg(cms_pkg::REG_ADMIT_THRESHOLD, 8'd0);
		calm = 1;
		random_phase(200);
		wait_idle();
		repeat (20) @(posedge clk);

		if (fail_count == 0)
			$display("tb_count_min_frequency_sketch_top: PASS");
		else
			$display("tb_count_min_frequency_sketch_top: FAIL");
		$finish;
	end

endmodule

[count_min_frequency_sketch_top.f]
rtl/cms_pkg.sv
rtl/cms_ram.sv
rtl/cms_ctrl.sv
rtl/cms_dp.sv
rtl/count_min_frequency_sketch_top.sv
bench/tb_count_min_frequency_sketch_top.sv
